FILE: rtl/core/mrtu_pkg.sv
// Shared types and constants for the Modbus RTU slave frame engine.
// Used by mrtu_ctrl, mrtu_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int REG_WORDS   = 64;
    localparam int FA_W        = $clog2(FRAME_BYTES);   // frame store address
    localparam int RA_W        = $clog2(REG_WORDS);     // register file address

    localparam logic [7:0] ADDR_MAX = 8'd247;

    // Modbus function codes
    localparam logic [7:0] FC_RD_COILS   = 8'd1;
    localparam logic [7:0] FC_RD_INPUTS  = 8'd2;
    localparam logic [7:0] FC_RD_HOLD    = 8'd3;
    localparam logic [7:0] FC_RD_INREG   = 8'd4;
    localparam logic [7:0] FC_WR_COIL    = 8'd5;
    localparam logic [7:0] FC_WR_REG     = 8'd6;
    localparam logic [7:0] FC_EXC_STATUS = 8'd7;
    localparam logic [7:0] FC_WR_COILS   = 8'd15;
    localparam logic [7:0] FC_WR_REGS    = 8'd16;

    // Configuration register indexes
    localparam logic CFG_SLAVE_ID  = 1'b0;
    localparam logic CFG_REG_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ACT_RECV = 2'd0,
        ACT_EOF  = 2'd1,
        ACT_PULL = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_ADDR  = 2'd1,
        ERR_CRC   = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        FN_RCOIL,
        FN_RREG,
        FN_WCOIL,
        FN_WREG,
        FN_EXC,
        FN_WCOILS,
        FN_WREGS,
        FN_NONE
    } fn_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RECV,
        OP_EOF,
        OP_PULL_RD,
        OP_PULL_OUT,
        OP_HDR,
        OP_SET_ERR,
        OP_CRC_INIT,
        OP_CRC_RD,
        OP_CRC_FEED,
        OP_LOOP_INIT,
        OP_CR_RD,
        OP_CR_BIT,
        OP_RR_RD,
        OP_RR_HI,
        OP_RR_LO,
        OP_HDRBYTE,
        OP_F5_RD,
        OP_F5_WR,
        OP_F6_WR,
        OP_WC_RD,
        OP_WC_WR,
        OP_WR_RD,
        OP_WR_HI,
        OP_WR_LO,
        OP_Q_LO,
        OP_Q_HI,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PULL,
        ST_LEN,
        ST_HDR,
        ST_ADDR,
        ST_CRC_RD,
        ST_CRC_FEED,
        ST_DISPATCH,
        ST_CR_RD,
        ST_CR_BIT,
        ST_RR_RD,
        ST_RR_HI,
        ST_RR_LO,
        ST_HDRBYTE,
        ST_F5_RD,
        ST_F5_WR,
        ST_F6,
        ST_WC_RD,
        ST_WC_WR,
        ST_WR_RD,
        ST_WR_HI,
        ST_WR_LO,
        ST_QUEUE,
        ST_Q_HI,
        ST_FIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        err_t   err;
        logic   crc_reply;   // CRC pass covers the reply, not the request
    } dp_cmd_t;

    typedef struct packed {
        logic short_frame;
        logic hdr_last;
        logic addr_bad;
        logic addr_skip;
        logic crc_more;
        logic crc_bad;
        logic range_err;
        fn_t  fn;
        logic more_n;
        logic wc_more;
        logic wr_more;
        logic bcast;
        logic tx_pending;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/mrtu_ctrl.sv
// Sequencer for the frame engine: walks header, CRC, function and reply steps.
// Depends on mrtu_pkg; drives mrtu_datapath through dp_cmd_t / dp_status_t.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire [1:0]            action,
    input  mrtu_pkg::dp_status_t status,
    output mrtu_pkg::dp_cmd_t    cmd,
    output logic                 busy
);
    import mrtu_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        phase_reg, phase_next;   // 0: request CRC check, 1: reply CRC

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd.op        = OP_NONE;
        cmd.err       = ERR_NONE;
        cmd.crc_reply = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action_t'(action))
                        ACT_RECV: cmd.op = OP_RECV;
                        ACT_EOF:
                        begin
                            cmd.op     = OP_EOF;
                            state_next = ST_LEN;
                        end
                        ACT_PULL:
                        begin
                            if (status.tx_pending)
                            begin
                                cmd.op     = OP_PULL_RD;
                                state_next = ST_PULL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PULL:
            begin
                cmd.op     = OP_PULL_OUT;
                state_next = ST_IDLE;
            end
            ST_LEN:
                state_next = status.short_frame ? ST_DONE : ST_HDR;
            ST_HDR:
            begin
                cmd.op = OP_HDR;
                if (status.hdr_last)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if (status.addr_bad)
                begin
                    cmd.op     = OP_SET_ERR;
                    cmd.err    = ERR_ADDR;
                    state_next = ST_DONE;
                end
                else if (status.addr_skip)
                    state_next = ST_DONE;
                else
                begin
                    cmd.op     = OP_CRC_INIT;
                    phase_next = 1'b0;
                    state_next = ST_CRC_RD;
                end
            end
            ST_CRC_RD:
            begin
                if (status.crc_more)
                begin
                    cmd.op     = OP_CRC_RD;
                    state_next = ST_CRC_FEED;
                end
                else if (phase_reg)
                begin
                    cmd.op     = OP_Q_LO;
                    state_next = ST_Q_HI;
                end
                else if (status.crc_bad)
                begin
                    cmd.op     = OP_SET_ERR;
                    cmd.err    = ERR_CRC;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_DISPATCH;
            end
            ST_CRC_FEED:
            begin
                cmd.op     = OP_CRC_FEED;
                state_next = ST_CRC_RD;
            end
            ST_DISPATCH:
            begin
                if (status.fn == FN_NONE)
                begin
                    cmd.op     = OP_SET_ERR;
                    state_next = ST_DONE;
                end
                else if (status.range_err)
                begin
                    cmd.op     = OP_SET_ERR;
                    cmd.err    = ERR_RANGE;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op = OP_LOOP_INIT;
                    case (status.fn)
                        FN_RCOIL:  state_next = ST_CR_RD;
                        FN_RREG:   state_next = ST_RR_RD;
                        FN_WCOIL:  state_next = ST_F5_RD;
                        FN_WREG:   state_next = ST_F6;
                        FN_EXC:    state_next = ST_HDRBYTE;
                        FN_WCOILS: state_next = ST_WC_RD;
                        FN_WREGS:  state_next = ST_WR_RD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            // read coils: a register read, then a bit step per coil
            ST_CR_RD:
            begin
                if (status.more_n)
                begin
                    cmd.op     = OP_CR_RD;
                    state_next = ST_CR_BIT;
                end
                else
                    state_next = ST_HDRBYTE;
            end
            ST_CR_BIT:
            begin
                cmd.op     = OP_CR_BIT;
                state_next = ST_CR_RD;
            end
            // read registers: a register read, then high and low byte writes per word
            ST_RR_RD:
            begin
                if (status.more_n)
                begin
                    cmd.op     = OP_RR_RD;
                    state_next = ST_RR_HI;
                end
                else
                    state_next = ST_HDRBYTE;
            end
            ST_RR_HI:
            begin
                cmd.op     = OP_RR_HI;
                state_next = ST_RR_LO;
            end
            ST_RR_LO:
            begin
                cmd.op     = OP_RR_LO;
                state_next = ST_RR_RD;
            end
            ST_HDRBYTE:
            begin
                cmd.op     = OP_HDRBYTE;
                state_next = ST_QUEUE;
            end
            ST_F5_RD:
            begin
                cmd.op     = OP_F5_RD;
                state_next = ST_F5_WR;
            end
            ST_F5_WR:
            begin
                cmd.op     = OP_F5_WR;
                state_next = ST_QUEUE;
            end
            ST_F6:
            begin
                cmd.op     = OP_F6_WR;
                state_next = ST_QUEUE;
            end
            // write coils: read-modify-write per bit
            ST_WC_RD:
            begin
                if (status.wc_more)
                begin
                    cmd.op     = OP_WC_RD;
                    state_next = ST_WC_WR;
                end
                else
                    state_next = ST_QUEUE;
            end
            ST_WC_WR:
            begin
                cmd.op     = OP_WC_WR;
                state_next = ST_WC_RD;
            end
            // write registers: two frame reads then one register write
            ST_WR_RD:
            begin
                if (status.wr_more)
                begin
                    cmd.op     = OP_WR_RD;
                    state_next = ST_WR_HI;
                end
                else
                    state_next = ST_QUEUE;
            end
            ST_WR_HI:
            begin
                cmd.op     = OP_WR_HI;
                state_next = ST_WR_LO;
            end
            ST_WR_LO:
            begin
                cmd.op     = OP_WR_LO;
                state_next = ST_WR_RD;
            end
            ST_QUEUE:
            begin
                if (status.bcast)
                begin
                    cmd.op     = OP_SET_ERR;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op        = OP_CRC_INIT;
                    cmd.crc_reply = 1'b1;
                    phase_next    = 1'b1;
                    state_next    = ST_CRC_RD;
                end
            end
            ST_Q_HI:
            begin
                cmd.op     = OP_Q_HI;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.op     = OP_SET_ERR;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.op     = OP_EMIT;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/mrtu_datapath.sv
// Datapath: frame store, register file, CRC-16 unit, loop counter, result regs.
// Depends on mrtu_pkg; commanded by mrtu_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mrtu_pkg::dp_cmd_t    cmd,
    output mrtu_pkg::dp_status_t status,
    input  wire [7:0]            data_byte,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire [7:0]            cfg_data,
    output logic                 tx_valid,
    output logic [7:0]           tx_byte,
    output logic                 tx_last,
    output logic [1:0]           error_code
);
    import mrtu_pkg::*;

    // one byte through the reflected 0xA001 polynomial
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++)
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    // Memories
    logic [7:0]  fmem [FRAME_BYTES];
    logic [15:0] rmem [REG_WORDS];

    // Control and status registers
    logic [7:0]  slave_id_reg;
    logic [6:0]  reg_count_reg;
    logic [8:0]  rx_len_reg;
    logic [8:0]  tx_len_reg;
    logic [8:0]  tx_pos_reg;
    logic [1:0]  last_err_reg;
    logic [3:0]  hdr_k_reg;
    logic [REG_WORDS-1:0] vld_reg;
    logic        tx_valid_reg;

    // Work registers (no reset needed)
    logic [8:0]  len_reg;
    logic [7:0]  addr_b_reg;
    logic [7:0]  func_reg;
    logic [15:0] a_reg;
    logic [15:0] n_reg;
    logic [7:0]  b6_reg;
    logic [15:0] rxcrc_reg;
    logic [15:0] crc_reg;
    logic [8:0]  crc_len_reg;
    logic [15:0] i_reg;
    logic [7:0]  acc_reg;
    logic [7:0]  hi_reg;
    logic [7:0]  frd_reg;
    logic [15:0] rrd_reg;
    logic        rvld_reg;
    logic [7:0]  tx_byte_reg;
    logic        tx_last_reg;
    logic [1:0]  err_out_reg;

    // Memory port controls
    logic          f_we, f_re, r_we, r_re;
    logic [FA_W-1:0] f_waddr, f_raddr;
    logic [7:0]    f_wdata;
    logic [RA_W-1:0] r_waddr, r_raddr;
    logic [15:0]   r_wdata;

    // Derived values
    logic [6:0]  rc;
    logic [10:0] rc16;
    logic [16:0] sum_ai;
    logic [13:0] nbytes;
    logic [7:0]  words;
    logic [8:0]  qlen;
    logic [15:0] rword;
    logic        coil_bit;
    logic [7:0]  acc_next;
    logic        flush;
    logic        pull_last;
    fn_t         fn;
    logic [15:0] wc_word;
    logic [15:0] f5_word;
    logic [7:0]  hdr_addr;

    assign rc      = (reg_count_reg > 7'(REG_WORDS)) ? 7'(REG_WORDS) : reg_count_reg;
    assign rc16    = {rc, 4'b0000};
    assign sum_ai  = {1'b0, a_reg} + {1'b0, i_reg};
    assign nbytes  = 14'(({1'b0, n_reg} + 17'd7) >> 3);
    assign words   = 8'(({1'b0, b6_reg} + 9'd1) >> 1);
    assign rword   = rvld_reg ? rrd_reg : 16'h0000;
    assign coil_bit  = (sum_ai < {6'd0, rc16}) & rword[sum_ai[3:0]];
    assign acc_next  = acc_reg | (8'(coil_bit) << i_reg[2:0]);
    assign flush     = (i_reg[2:0] == 3'd7) || (i_reg + 16'd1 == n_reg);
    assign pull_last = (tx_pos_reg + 9'd1 == tx_len_reg);

    // single coil and multiple coil updates of one word
    assign f5_word = (rword & ~(16'h0001 << a_reg[3:0]))
                   | (16'((n_reg != 16'h0000)) << a_reg[3:0]);
    assign wc_word = (rword & ~(16'h0001 << sum_ai[3:0]))
                   | (16'(frd_reg[i_reg[2:0]]) << sum_ai[3:0]);

    // Function decode
    always_comb
    begin
        case (func_reg)
            FC_RD_COILS, FC_RD_INPUTS: fn = FN_RCOIL;
            FC_RD_HOLD, FC_RD_INREG:   fn = FN_RREG;
            FC_WR_COIL:                fn = FN_WCOIL;
            FC_WR_REG:                 fn = FN_WREG;
            FC_EXC_STATUS:             fn = FN_EXC;
            FC_WR_COILS:               fn = FN_WCOILS;
            FC_WR_REGS:                fn = FN_WREGS;
            default:                   fn = FN_NONE;
        endcase
    end

    // Reply length without CRC
    always_comb
    begin
        case (fn)
            FN_RCOIL: qlen = 9'd3 + {1'b0, nbytes[7:0]};
            FN_RREG:  qlen = 9'd3 + {1'b0, n_reg[6:0], 1'b0};
            FN_EXC:   qlen = 9'd3;
            default:  qlen = 9'd6;
        endcase
    end

    // Header fetch order: bytes 0..6, then received CRC low and high
    always_comb
    begin
        case (hdr_k_reg)
            4'd7:    hdr_addr = 8'(len_reg - 9'd2);
            4'd8:    hdr_addr = 8'(len_reg - 9'd1);
            default: hdr_addr = {4'd0, hdr_k_reg};
        endcase
    end

    // Status to the controller
    always_comb
    begin
        status.short_frame = (len_reg < 9'd4);
        status.hdr_last    = (hdr_k_reg == 4'd9);
        status.addr_bad    = (addr_b_reg > ADDR_MAX);
        status.addr_skip   = (addr_b_reg != 8'd0) && (addr_b_reg != slave_id_reg);
        status.crc_more    = (i_reg < {7'd0, crc_len_reg});
        status.crc_bad     = (crc_reg != rxcrc_reg);
        status.fn          = fn;
        status.more_n      = (i_reg < n_reg);
        status.wc_more     = (i_reg < n_reg) && (sum_ai < {6'd0, rc16});
        status.wr_more     = (i_reg < {8'd0, words}) && (sum_ai < {10'd0, rc});
        status.bcast       = (addr_b_reg == 8'd0);
        status.tx_pending  = (tx_pos_reg < tx_len_reg);
        case (fn)
            FN_RCOIL:  status.range_err = (a_reg >= {5'd0, rc16}) || (nbytes > 14'd251);
            FN_RREG:   status.range_err = (a_reg >= {9'd0, rc}) || (n_reg > 16'd125);
            FN_WCOIL,
            FN_WCOILS: status.range_err = (a_reg >= {5'd0, rc16});
            FN_WREG,
            FN_WREGS:  status.range_err = (a_reg >= {9'd0, rc});
            default:   status.range_err = 1'b0;
        endcase
    end

    // Memory port selection
    always_comb
    begin
        f_we    = 1'b0;
        f_re    = 1'b0;
        r_we    = 1'b0;
        r_re    = 1'b0;
        f_waddr = '0;
        f_raddr = '0;
        f_wdata = '0;
        r_waddr = '0;
        r_raddr = '0;
        r_wdata = '0;
        case (cmd.op)
            OP_RECV:
            begin
                f_we    = !rx_len_reg[8];
                f_waddr = rx_len_reg[7:0];
                f_wdata = data_byte;
            end
            OP_PULL_RD:
            begin
                f_re    = 1'b1;
                f_raddr = tx_pos_reg[7:0];
            end
            OP_HDR:
            begin
                f_re    = 1'b1;
                f_raddr = hdr_addr;
            end
            OP_CRC_RD:
            begin
                f_re    = 1'b1;
                f_raddr = i_reg[7:0];
            end
            OP_CR_RD:
            begin
                r_re    = 1'b1;
                r_raddr = sum_ai[9:4];
            end
            OP_CR_BIT:
            begin
                f_we    = flush;
                f_waddr = 8'd3 + i_reg[10:3];
                f_wdata = acc_next;
            end
            OP_RR_RD:
            begin
                r_re    = 1'b1;
                r_raddr = sum_ai[5:0];
            end
            OP_RR_HI:
            begin
                f_we    = 1'b1;
                f_waddr = 8'd3 + {i_reg[6:0], 1'b0};
                f_wdata = (sum_ai < {10'd0, rc}) ? rword[15:8] : 8'h00;
            end
            OP_RR_LO:
            begin
                f_we    = 1'b1;
                f_waddr = 8'd4 + {i_reg[6:0], 1'b0};
                f_wdata = (sum_ai < {10'd0, rc}) ? rword[7:0] : 8'h00;
            end
            OP_HDRBYTE:
            begin
                f_we    = 1'b1;
                f_waddr = 8'd2;
                case (fn)
                    FN_RCOIL: f_wdata = nbytes[7:0];
                    FN_RREG:  f_wdata = {n_reg[6:0], 1'b0};
                    default:  f_wdata = {6'd0, last_err_reg};
                endcase
            end
            OP_F5_RD:
            begin
                r_re    = 1'b1;
                r_raddr = a_reg[9:4];
            end
            OP_F5_WR:
            begin
                r_we    = 1'b1;
                r_waddr = a_reg[9:4];
                r_wdata = f5_word;
            end
            OP_F6_WR:
            begin
                r_we    = 1'b1;
                r_waddr = a_reg[5:0];
                r_wdata = n_reg;
            end
            OP_WC_RD:
            begin
                f_re    = 1'b1;
                f_raddr = 8'd7 + {1'b0, i_reg[9:3]};
                r_re    = 1'b1;
                r_raddr = sum_ai[9:4];
            end
            OP_WC_WR:
            begin
                r_we    = 1'b1;
                r_waddr = sum_ai[9:4];
                r_wdata = wc_word;
            end
            OP_WR_RD:
            begin
                f_re    = 1'b1;
                f_raddr = 8'd7 + {1'b0, i_reg[5:0], 1'b0};
            end
            OP_WR_HI:
            begin
                f_re    = 1'b1;
                f_raddr = 8'd8 + {1'b0, i_reg[5:0], 1'b0};
            end
            OP_WR_LO:
            begin
                r_we    = 1'b1;
                r_waddr = sum_ai[5:0];
                r_wdata = {hi_reg, frd_reg};
            end
            OP_Q_LO:
            begin
                f_we    = 1'b1;
                f_waddr = qlen[7:0];
                f_wdata = crc_reg[7:0];
            end
            OP_Q_HI:
            begin
                f_we    = 1'b1;
                f_waddr = 8'(qlen + 9'd1);
                f_wdata = crc_reg[15:8];
            end
            default: ;
        endcase
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (f_we)
            fmem[f_waddr] <= f_wdata;
        if (f_re)
            frd_reg <= fmem[f_raddr];
    end

    // Register file
    always_ff @(posedge clk)
    begin
        if (r_we)
            rmem[r_waddr] <= r_wdata;
        if (r_re)
        begin
            rrd_reg  <= rmem[r_raddr];
            rvld_reg <= vld_reg[r_raddr];
        end
    end

    // Control state: config, lengths, error, valid bits, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_id_reg  <= 8'd1;
            reg_count_reg <= 7'd64;
            rx_len_reg    <= '0;
            tx_len_reg    <= '0;
            tx_pos_reg    <= '0;
            last_err_reg  <= ERR_NONE;
            hdr_k_reg     <= '0;
            vld_reg       <= '0;
            tx_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLAVE_ID:  slave_id_reg  <= cfg_data;
                    CFG_REG_COUNT: reg_count_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (r_we)
                vld_reg[r_waddr] <= 1'b1;
            tx_valid_reg <= (cmd.op == OP_EMIT) || (cmd.op == OP_PULL_OUT);
            case (cmd.op)
                OP_RECV:
                begin
                    tx_len_reg <= '0;
                    tx_pos_reg <= '0;
                    if (!rx_len_reg[8])
                        rx_len_reg <= rx_len_reg + 9'd1;
                end
                OP_EOF:
                begin
                    tx_len_reg <= '0;
                    tx_pos_reg <= '0;
                    rx_len_reg <= '0;
                    hdr_k_reg  <= '0;
                end
                OP_HDR:     hdr_k_reg <= hdr_k_reg + 4'd1;
                OP_SET_ERR: last_err_reg <= cmd.err;
                OP_PULL_OUT:
                begin
                    if (pull_last)
                    begin
                        tx_pos_reg <= '0;
                        tx_len_reg <= '0;
                    end
                    else
                        tx_pos_reg <= tx_pos_reg + 9'd1;
                end
                OP_Q_HI:
                begin
                    tx_len_reg <= qlen + 9'd2;
                    tx_pos_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Work registers: header fields, CRC, loop counter, result payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_EOF: len_reg <= rx_len_reg;
            OP_HDR:
            begin
                case (hdr_k_reg)
                    4'd1: addr_b_reg       <= frd_reg;
                    4'd2: func_reg         <= frd_reg;
                    4'd3: a_reg[15:8]      <= frd_reg;
                    4'd4: a_reg[7:0]       <= frd_reg;
                    4'd5: n_reg[15:8]      <= frd_reg;
                    4'd6: n_reg[7:0]       <= frd_reg;
                    4'd7: b6_reg           <= frd_reg;
                    4'd8: rxcrc_reg[7:0]   <= frd_reg;
                    4'd9: rxcrc_reg[15:8]  <= frd_reg;
                    default: ;
                endcase
            end
            OP_CRC_INIT:
            begin
                crc_reg     <= 16'hFFFF;
                i_reg       <= '0;
                crc_len_reg <= cmd.crc_reply ? qlen : (len_reg - 9'd2);
            end
            OP_CRC_FEED:
            begin
                crc_reg <= crc_byte(crc_reg, frd_reg);
                i_reg   <= i_reg + 16'd1;
            end
            OP_LOOP_INIT:
            begin
                i_reg   <= '0;
                acc_reg <= '0;
            end
            OP_CR_BIT:
            begin
                acc_reg <= flush ? 8'h00 : acc_next;
                i_reg   <= i_reg + 16'd1;
            end
            OP_RR_LO,
            OP_WC_WR,
            OP_WR_LO:   i_reg  <= i_reg + 16'd1;
            OP_WR_HI:   hi_reg <= frd_reg;
            OP_PULL_OUT:
            begin
                tx_byte_reg <= frd_reg;
                tx_last_reg <= pull_last;
                err_out_reg <= last_err_reg;
            end
            OP_EMIT:
            begin
                tx_byte_reg <= 8'h00;
                tx_last_reg <= 1'b0;
                err_out_reg <= last_err_reg;
            end
            default: ;
        endcase
    end

    assign tx_valid   = tx_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign tx_last    = tx_last_reg;
    assign error_code = err_out_reg;

`ifndef ASSERT_OFF
    // drain pointer never passes the queued length
    a_tx_pos: assert property (@(posedge clk) disable iff (!rst_n)
        tx_pos_reg <= tx_len_reg)
        else $error("tx position past reply length");

    // receive count saturates at the store size
    a_rx_len: assert property (@(posedge clk) disable iff (!rst_n)
        rx_len_reg <= 9'(FRAME_BYTES))
        else $error("rx length past frame store");

    // a queued reply holds at least address, function, one byte and CRC
    a_tx_len: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_len_reg == 9'd0) || (tx_len_reg >= 9'd5))
        else $error("reply length too short");

    // a result transfer follows only an emit or pull command
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid_reg |-> ($past(cmd.op) == OP_EMIT) || ($past(cmd.op) == OP_PULL_OUT))
        else $error("result strobe without command");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/modbus_rtu_slave_frame_engine.sv
// Modbus RTU slave frame engine top level: sequencer plus datapath.
// Receive byte: busy stays low. Pull: busy high in ST_PULL, strobe in the cycle busy drops.
// End of frame: length check, header fetch, request CRC check, function loop and, when
// a reply is queued, the reply CRC, then a result strobe. One item at a time; busy high
// while working. Results cannot be stalled.
// Reset (async, active low) clears lengths, error, register file valid bits.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_slave_frame_engine (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [1:0]  action,
    input  wire [7:0]  data_byte,
    input  wire        cfg_we,
    input  wire        cfg_index,
    input  wire [7:0]  cfg_data,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       tx_last,
    output logic [1:0] error_code
);
    import mrtu_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mrtu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mrtu_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .data_byte  (data_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .tx_last    (tx_last),
        .error_code (error_code)
    );

endmodule

`default_nettype wire
